### design/tse_pkg.sv
// ---------------------------------------------------------------------------
// tse_pkg: shared types and constants for the tftp server transfer engine
// Opcodes, mode codes, status codes and the item structs of both channels.
// ---------------------------------------------------------------------------
package tse_pkg;

    // block size in bytes
    localparam int unsigned BLOCK_BYTES = 512;
    localparam logic [9:0]  BLOCK_LEN   = 10'(BLOCK_BYTES);

    // item kinds
    localparam logic [1:0] REQ_PACKET = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_BLOCK  = 2'd2;

    // received opcodes
    localparam logic [7:0] OP_RRQ   = 8'd1;
    localparam logic [7:0] OP_WRQ   = 8'd2;
    localparam logic [7:0] OP_DATA  = 8'd3;
    localparam logic [7:0] OP_ACK   = 8'd4;
    localparam logic [7:0] OP_ERROR = 8'd5;

    // sent opcodes
    localparam logic [2:0] SEND_NONE  = 3'd0;
    localparam logic [2:0] SEND_DATA  = 3'd3;
    localparam logic [2:0] SEND_ACK   = 3'd4;
    localparam logic [2:0] SEND_ERROR = 3'd5;

    // error code for a file that could not be opened
    localparam logic [15:0] ERR_NOT_FOUND = 16'd1;

    // status codes
    localparam logic [2:0] ST_RUNNING   = 3'd0;
    localparam logic [2:0] ST_FINISHED  = 3'd1;
    localparam logic [2:0] ST_PEER_ERR  = 3'd2;
    localparam logic [2:0] ST_RETRY_OUT = 3'd3;
    localparam logic [2:0] ST_OPEN_FAIL = 3'd4;

    // transfer modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_FETCH   = 2'd1;
    localparam logic [1:0] MODE_ACKWAIT = 2'd2;
    localparam logic [1:0] MODE_WRITE   = 2'd3;

    // configuration register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_RETRIES = 1'b1;

    // configuration reset values
    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [3:0]  RETRIES_RESET = 4'd10;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  opcode;
        logic [15:0] block_num;
        logic [9:0]  payload_len;
        logic        file_ok;
    } req_t;

    typedef struct packed {
        logic        send_valid;
        logic [2:0]  send_opcode;
        logic [15:0] send_block;
        logic [9:0]  send_len;
        logic        is_retransmit;
        logic        store_payload;
        logic        fetch_next;
        logic [2:0]  status;
        logic [31:0] total_bytes;
    } rsp_t;

endpackage

### design/tse_if.sv
// ---------------------------------------------------------------------------
// tse_if: channel interfaces of the transfer engine
// Request channel (headers, ticks, local blocks) and response channel.
// ---------------------------------------------------------------------------
interface tse_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  opcode;
    logic [15:0] block_num;
    logic [9:0]  payload_len;
    logic        file_ok;

    modport source (output valid, req_type, opcode, block_num, payload_len, file_ok,
                    input ready);
    modport sink   (input valid, req_type, opcode, block_num, payload_len, file_ok,
                    output ready);
endinterface

interface tse_rsp_if;
    logic        valid;
    logic        ready;
    logic        send_valid;
    logic [2:0]  send_opcode;
    logic [15:0] send_block;
    logic [9:0]  send_len;
    logic        is_retransmit;
    logic        store_payload;
    logic        fetch_next;
    logic [2:0]  status;
    logic [31:0] total_bytes;

    modport source (output valid, send_valid, send_opcode, send_block, send_len,
                    is_retransmit, store_payload, fetch_next, status, total_bytes,
                    input ready);
    modport sink   (input valid, send_valid, send_opcode, send_block, send_len,
                    is_retransmit, store_payload, fetch_next, status, total_bytes,
                    output ready);
endinterface

### design/tftp_server_transfer_engine_top.sv
// ---------------------------------------------------------------------------
// tftp_server_transfer_engine_top: packet-level tftp server controller
// Input register, transfer state machine and response register.
// ---------------------------------------------------------------------------
// Usage:
//   req carries received packet headers, 1 ms ticks and local block
//   notifications; rsp carries at most one response item per request item
//   (packet to send, store/fetch requests, status and byte count). Items
//   that do not apply in the current mode are consumed without a response.
//   A request item is held in the input register, handled by the transfer
//   state machine and its response is held in the response register.
//   Throughput: one item per cycle while rsp is not stalled; the single state
//   update per item in the transfer state machine sets that figure.
//   timeout_ticks and max_retries are written through cfg_we / cfg_index /
//   cfg_data, by the user only while no transfer item is in flight; unchecked.
//   Reset: mode idle, all counters cleared, timeout 5000 ticks, 10 retries.
//   Receiver stall: the response register holds its item; the input register
//   still takes one more item, after which req.ready drops until rsp moves.
// ---------------------------------------------------------------------------
module tftp_server_transfer_engine_top
(
    input  logic        clk,
    input  logic        rst_n,
    tse_req_if.sink     req,
    tse_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic          in_valid_reg;
    tse_pkg::req_t in_item_reg;
    logic          out_valid_reg;
    tse_pkg::rsp_t out_item_reg;

    logic          out_free;
    logic          item_fire;
    logic          has_rsp;
    tse_pkg::rsp_t rsp_item;

    // handshake control
    assign out_free  = !out_valid_reg || rsp.ready;
    assign item_fire = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || item_fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_item_reg.req_type    <= req.req_type;
            in_item_reg.opcode      <= req.opcode;
            in_item_reg.block_num   <= req.block_num;
            in_item_reg.payload_len <= req.payload_len;
            in_item_reg.file_ok     <= req.file_ok;
        end
    end

    // transfer state machine
    tse_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item_fire (item_fire),
        .item      (in_item_reg),
        .has_rsp   (has_rsp),
        .rsp       (rsp_item)
    );

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= item_fire && has_rsp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire && has_rsp)
        begin
            out_item_reg <= rsp_item;
        end
    end

    // response channel
    assign rsp.valid         = out_valid_reg;
    assign rsp.send_valid    = out_item_reg.send_valid;
    assign rsp.send_opcode   = out_item_reg.send_opcode;
    assign rsp.send_block    = out_item_reg.send_block;
    assign rsp.send_len      = out_item_reg.send_len;
    assign rsp.is_retransmit = out_item_reg.is_retransmit;
    assign rsp.store_payload = out_item_reg.store_payload;
    assign rsp.fetch_next    = out_item_reg.fetch_next;
    assign rsp.status        = out_item_reg.status;
    assign rsp.total_bytes   = out_item_reg.total_bytes;

endmodule

### design/tse_ctrl.sv
// ---------------------------------------------------------------------------
// tse_ctrl: transfer state machine of the tftp server engine
// Holds mode, counters and configuration; decides the response of one item.
// ---------------------------------------------------------------------------
module tse_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                item_fire,
    input  tse_pkg::req_t       item,
    output logic                has_rsp,
    output tse_pkg::rsp_t       rsp
);

    logic [15:0] timeout_reg;
    logic [3:0]  retries_reg;

    logic [1:0]  mode_reg,      mode_next;
    logic [15:0] block_reg,     block_next;
    logic [9:0]  last_len_reg,  last_len_next;
    logic [15:0] elapsed_reg,   elapsed_next;
    logic [3:0]  retry_reg,     retry_next;
    logic [31:0] total_reg,     total_next;

    logic [9:0]  len;
    logic [16:0] tick_count;
    logic        is_rq;

    // saturate payload length to the block size
    assign len = (item.payload_len > tse_pkg::BLOCK_LEN) ? tse_pkg::BLOCK_LEN
                                                         : item.payload_len;
    assign tick_count = {1'b0, elapsed_reg} + 17'd1;
    assign is_rq = (item.opcode == tse_pkg::OP_RRQ) || (item.opcode == tse_pkg::OP_WRQ);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= tse_pkg::TIMEOUT_RESET;
            retries_reg <= tse_pkg::RETRIES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tse_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data;
                tse_pkg::CFG_RETRIES: retries_reg <= cfg_data[3:0];
                default:              timeout_reg <= timeout_reg;
            endcase
        end
    end

    // next state and response of one item
    always_comb
    begin
        mode_next     = mode_reg;
        block_next    = block_reg;
        last_len_next = last_len_reg;
        elapsed_next  = elapsed_reg;
        retry_next    = retry_reg;
        total_next    = total_reg;
        has_rsp       = 1'b0;
        rsp           = '0;

        unique case (mode_reg)
            tse_pkg::MODE_IDLE:
            begin
                if (item.req_type == tse_pkg::REQ_PACKET && is_rq)
                begin
                    has_rsp    = 1'b1;
                    total_next = '0;
                    if (!item.file_ok)
                    begin
                        rsp.send_valid  = 1'b1;
                        rsp.send_opcode = tse_pkg::SEND_ERROR;
                        rsp.send_block  = tse_pkg::ERR_NOT_FOUND;
                        rsp.status      = tse_pkg::ST_OPEN_FAIL;
                    end
                    else
                    begin
                        retry_next    = '0;
                        elapsed_next  = '0;
                        last_len_next = '0;
                        if (item.opcode == tse_pkg::OP_RRQ)
                        begin
                            mode_next      = tse_pkg::MODE_FETCH;
                            block_next     = 16'd1;
                            rsp.fetch_next = 1'b1;
                        end
                        else
                        begin
                            mode_next       = tse_pkg::MODE_WRITE;
                            block_next      = '0;
                            rsp.send_valid  = 1'b1;
                            rsp.send_opcode = tse_pkg::SEND_ACK;
                        end
                    end
                end
            end

            tse_pkg::MODE_FETCH:
            begin
                if (item.req_type == tse_pkg::REQ_BLOCK)
                begin
                    has_rsp         = 1'b1;
                    last_len_next   = len;
                    total_next      = total_reg + 32'(len);
                    elapsed_next    = '0;
                    retry_next      = '0;
                    mode_next       = tse_pkg::MODE_ACKWAIT;
                    rsp.send_valid  = 1'b1;
                    rsp.send_opcode = tse_pkg::SEND_DATA;
                    rsp.send_block  = block_reg;
                    rsp.send_len    = len;
                end
            end

            tse_pkg::MODE_ACKWAIT:
            begin
                if (item.req_type == tse_pkg::REQ_PACKET)
                begin
                    if (item.opcode == tse_pkg::OP_ACK && item.block_num == block_reg)
                    begin
                        has_rsp = 1'b1;
                        if (last_len_reg < tse_pkg::BLOCK_LEN)
                        begin
                            mode_next  = tse_pkg::MODE_IDLE;
                            rsp.status = tse_pkg::ST_FINISHED;
                        end
                        else
                        begin
                            block_next     = block_reg + 16'd1;
                            mode_next      = tse_pkg::MODE_FETCH;
                            rsp.fetch_next = 1'b1;
                        end
                    end
                    else if (item.opcode == tse_pkg::OP_ERROR)
                    begin
                        has_rsp    = 1'b1;
                        mode_next  = tse_pkg::MODE_IDLE;
                        rsp.status = tse_pkg::ST_PEER_ERR;
                    end
                end
                else if (item.req_type == tse_pkg::REQ_TICK)
                begin
                    if (tick_count >= {1'b0, timeout_reg})
                    begin
                        has_rsp      = 1'b1;
                        elapsed_next = '0;
                        if (retry_reg >= retries_reg)
                        begin
                            mode_next  = tse_pkg::MODE_IDLE;
                            rsp.status = tse_pkg::ST_RETRY_OUT;
                        end
                        else
                        begin
                            retry_next        = retry_reg + 4'd1;
                            rsp.send_valid    = 1'b1;
                            rsp.send_opcode   = tse_pkg::SEND_DATA;
                            rsp.send_block    = block_reg;
                            rsp.send_len      = last_len_reg;
                            rsp.is_retransmit = 1'b1;
                        end
                    end
                    else
                    begin
                        elapsed_next = tick_count[15:0];
                    end
                end
            end

            tse_pkg::MODE_WRITE:
            begin
                if (item.req_type == tse_pkg::REQ_PACKET && item.opcode == tse_pkg::OP_DATA)
                begin
                    has_rsp           = 1'b1;
                    block_next        = item.block_num;
                    total_next        = total_reg + 32'(len);
                    rsp.send_valid    = 1'b1;
                    rsp.send_opcode   = tse_pkg::SEND_ACK;
                    rsp.send_block    = item.block_num;
                    rsp.store_payload = 1'b1;
                    if (len < tse_pkg::BLOCK_LEN)
                    begin
                        mode_next  = tse_pkg::MODE_IDLE;
                        rsp.status = tse_pkg::ST_FINISHED;
                    end
                end
            end

            default:
            begin
                mode_next = tse_pkg::MODE_IDLE;
            end
        endcase

        rsp.total_bytes = total_next;
    end

    // transfer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= tse_pkg::MODE_IDLE;
            block_reg    <= '0;
            last_len_reg <= '0;
            elapsed_reg  <= '0;
            retry_reg    <= '0;
            total_reg    <= '0;
        end
        else if (item_fire)
        begin
            mode_reg     <= mode_next;
            block_reg    <= block_next;
            last_len_reg <= last_len_next;
            elapsed_reg  <= elapsed_next;
            retry_reg    <= retry_next;
            total_reg    <= total_next;
        end
    end

endmodule
